// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the timer queue RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/dtq_pkg.sv -----
// Package for the delta-list timer queue: item types, codes, defaults.
// No dependencies.
package dtq_pkg;

    localparam int TIMER_SLOTS_DEF = 16;
    localparam int DELAY_BITS_DEF  = 24;
    localparam int MAX_RESULTS     = 16;

    localparam logic [1:0] ACT_ADD  = 2'd0;
    localparam logic [1:0] ACT_DEL  = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_ZERO_DLY = 3'd1;
    localparam logic [2:0] ST_BUSY     = 3'd2;
    localparam logic [2:0] ST_DELETED  = 3'd3;
    localparam logic [2:0] ST_IDLE     = 3'd4;
    localparam logic [2:0] ST_EXPIRED  = 3'd5;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  timer_id;
        logic [23:0] delay;
    } t_item;

    typedef struct packed {
        logic [3:0] timer_id_res;
        logic [2:0] status;
        logic       no_expiry;
        logic       last;
    } t_result;

endpackage

// ----- rtl/dtq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/delta_timer_queue.sv -----
// Delta-list timer queue, top level.
// Depends on dtq_pkg, dtq_ram and assert_macros.svh.
//
// Usage:
//   Present an item on i_item and raise start; it is taken at a clock edge
//   where start is high and busy is low. Actions: add a timer, delete a
//   timer, or one tick. Results appear on o_result for exactly one cycle,
//   marked by o_strobe; the receiver cannot stall, so every result must be
//   taken in the cycle it is shown. The last result of an item has last set.
//   Add and delete give one result; a tick gives one result per expired
//   timer (at most sixteen) or a single result with no_expiry set.
//   Timing: rejected adds/deletes and empty-queue ticks answer the cycle
//   after acceptance with busy staying low; unknown actions give no result
//   and leave busy low. An add walks the entries ahead of its place, a
//   delete walks the entries ahead of the timer, and a tick handles one
//   expired timer at a time. The walk is bound by the single read port of
//   the slot RAM: it follows one link per cycle.
//   Reset (synchronous, active low) empties the queue; the slot RAM needs
//   no clearing because only the contents of pending slots are ever used.
module delta_timer_queue #(
    parameter int TIMER_SLOTS = dtq_pkg::TIMER_SLOTS_DEF,
    parameter int DELAY_BITS  = dtq_pkg::DELAY_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  dtq_pkg::t_item  i_item,
    output logic            busy,
    output logic            o_strobe,
    output dtq_pkg::t_result o_result
);

    `include "assert_macros.svh"

    localparam int SW  = $clog2(TIMER_SLOTS);
    localparam int CW  = $clog2(TIMER_SLOTS + 1);
    localparam int NW  = $clog2(dtq_pkg::MAX_RESULTS + 1);
    localparam int RW  = DELAY_BITS + SW;

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_AWALK   = 4'd1;
    localparam logic [3:0] S_AWR_ID  = 4'd2;
    localparam logic [3:0] S_AWR_PRV = 4'd3;
    localparam logic [3:0] S_DWALK   = 4'd4;
    localparam logic [3:0] S_DID     = 4'd5;
    localparam logic [3:0] S_DNX     = 4'd6;
    localparam logic [3:0] S_DWR_PRV = 4'd7;
    localparam logic [3:0] S_TCHK    = 4'd8;
    localparam logic [3:0] S_TFLUSH  = 4'd9;

    logic [3:0]             r_state, n_state;
    logic [TIMER_SLOTS-1:0] r_pending, n_pending;
    logic [SW-1:0]          r_head, n_head;
    logic [CW-1:0]          r_count, n_count;
    logic [SW-1:0]          r_id, n_id;
    logic [SW-1:0]          r_cur, n_cur;
    logic [SW-1:0]          r_prev, n_prev;
    logic [SW-1:0]          r_link, n_link;
    logic [DELAY_BITS-1:0]  r_rem, n_rem;
    logic [DELAY_BITS-1:0]  r_prv_dly, n_prv_dly;
    logic                   r_has_prv, n_has_prv;
    logic [CW-1:0]          r_k, n_k;
    logic                   r_first, n_first;
    logic                   r_have_pend, n_have_pend;
    logic [SW-1:0]          r_pend, n_pend;
    logic [NW-1:0]          r_nres, n_nres;
    logic                   r_strobe, n_strobe;
    dtq_pkg::t_result       r_res, n_res;

    // slot RAM: {delta, next}
    logic                  w_we;
    logic [SW-1:0]         w_waddr, w_raddr;
    logic [RW-1:0]         w_wdata, w_rdata;
    logic [DELAY_BITS-1:0] w_rd_dly;
    logic [SW-1:0]         w_rd_nxt;

    logic [SW-1:0]         w_in_id;
    logic [DELAY_BITS-1:0] w_in_dly;
    logic                  w_in_oor;
    logic                  w_accept;
    logic [CW-1:0]         w_k1;
    logic [DELAY_BITS-1:0] w_tdly;
    logic [NW-1:0]         w_nres1;

    dtq_ram #(
        .WIDTH (RW),
        .DEPTH (TIMER_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_dly = w_rdata[RW-1:SW];
    assign w_rd_nxt = w_rdata[SW-1:0];
    assign w_in_id  = SW'(i_item.timer_id);
    assign w_in_dly = DELAY_BITS'(i_item.delay);
    assign w_in_oor = int'(i_item.timer_id) >= TIMER_SLOTS;
    assign w_accept = start && (r_state == S_IDLE);
    assign w_k1     = CW'(r_k + 1'b1);
    assign w_nres1  = NW'(r_nres + 1'b1);
    // head delta after this tick's decrement; later heads are not lowered
    assign w_tdly   = (r_first && (w_rd_dly != '0)) ? DELAY_BITS'(w_rd_dly - 1'b1) : w_rd_dly;

    always_comb begin
        n_state     = r_state;
        n_pending   = r_pending;
        n_head      = r_head;
        n_count     = r_count;
        n_id        = r_id;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_link      = r_link;
        n_rem       = r_rem;
        n_prv_dly   = r_prv_dly;
        n_has_prv   = r_has_prv;
        n_k         = r_k;
        n_first     = r_first;
        n_have_pend = r_have_pend;
        n_pend      = r_pend;
        n_nres      = r_nres;
        n_strobe    = 1'b0;
        n_res       = r_res;
        w_we        = 1'b0;
        w_waddr     = r_cur;
        w_wdata     = '0;
        w_raddr     = r_cur;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_id      = w_in_id;
                    n_rem     = w_in_dly;
                    n_cur     = r_head;
                    n_k       = '0;
                    n_has_prv = 1'b0;
                    w_raddr   = r_head;
                    n_res.timer_id_res = i_item.timer_id;
                    n_res.no_expiry    = 1'b0;
                    n_res.last         = 1'b1;
                    case (i_item.action)
                        dtq_pkg::ACT_ADD: begin
                            if (w_in_oor || r_pending[w_in_id]) begin
                                n_strobe     = 1'b1;
                                n_res.status = dtq_pkg::ST_BUSY;
                            end else if (w_in_dly == '0) begin
                                n_strobe     = 1'b1;
                                n_res.status = dtq_pkg::ST_ZERO_DLY;
                            end else if (r_count == '0) begin
                                n_link  = '0;
                                n_state = S_AWR_ID;
                            end else begin
                                n_state = S_AWALK;
                            end
                        end
                        dtq_pkg::ACT_DEL: begin
                            if (w_in_oor || !r_pending[w_in_id]) begin
                                n_strobe     = 1'b1;
                                n_res.status = dtq_pkg::ST_IDLE;
                            end else if (r_head == w_in_id) begin
                                n_state = S_DID;
                            end else begin
                                n_state = S_DWALK;
                            end
                        end
                        dtq_pkg::ACT_TICK: begin
                            n_first     = 1'b1;
                            n_have_pend = 1'b0;
                            n_nres      = '0;
                            if (r_count == '0) begin
                                n_strobe           = 1'b1;
                                n_res.timer_id_res = '0;
                                n_res.status       = dtq_pkg::ST_EXPIRED;
                                n_res.no_expiry    = 1'b1;
                            end else begin
                                n_state = S_TCHK;
                            end
                        end
                        default: begin
                            // unknown action: drop without a result
                        end
                    endcase
                end
            end

            S_AWALK: begin
                if (r_rem < w_rd_dly) begin
                    // land in front of cur: shrink its delta
                    w_we    = 1'b1;
                    w_waddr = r_cur;
                    w_wdata = {DELAY_BITS'(w_rd_dly - r_rem), w_rd_nxt};
                    n_link  = r_cur;
                    n_state = S_AWR_ID;
                end else begin
                    n_rem     = DELAY_BITS'(r_rem - w_rd_dly);
                    n_prev    = r_cur;
                    n_prv_dly = w_rd_dly;
                    n_has_prv = 1'b1;
                    n_cur     = w_rd_nxt;
                    n_k       = w_k1;
                    w_raddr   = w_rd_nxt;
                    if (w_k1 >= r_count) begin
                        n_link  = '0;
                        n_state = S_AWR_ID;
                    end
                end
            end

            S_AWR_ID: begin
                w_we    = 1'b1;
                w_waddr = r_id;
                w_wdata = {r_rem, r_link};
                n_pending[r_id] = 1'b1;
                n_count = CW'(r_count + 1'b1);
                if (r_has_prv) begin
                    n_state = S_AWR_PRV;
                end else begin
                    n_head             = r_id;
                    n_strobe           = 1'b1;
                    n_res.status       = dtq_pkg::ST_ADDED;
                    n_state            = S_IDLE;
                end
            end

            S_AWR_PRV: begin
                w_we         = 1'b1;
                w_waddr      = r_prev;
                w_wdata      = {r_prv_dly, r_id};
                n_strobe     = 1'b1;
                n_res.status = dtq_pkg::ST_ADDED;
                n_state      = S_IDLE;
            end

            S_DWALK: begin
                n_prev    = r_cur;
                n_prv_dly = w_rd_dly;
                n_has_prv = 1'b1;
                n_cur     = w_rd_nxt;
                n_k       = w_k1;
                w_raddr   = w_rd_nxt;
                if (w_rd_nxt == r_id) begin
                    n_state = S_DID;
                end
            end

            S_DID: begin
                // hold the deleted slot's delta in r_rem for the fold
                n_rem   = w_rd_dly;
                n_link  = w_rd_nxt;
                w_raddr = w_rd_nxt;
                if (w_k1 < r_count) begin
                    n_state = S_DNX;
                end else begin
                    n_pending[r_id] = 1'b0;
                    n_count = CW'(r_count - 1'b1);
                    if (r_count == CW'(1)) begin
                        n_head = '0;
                    end
                    n_strobe     = 1'b1;
                    n_res.status = dtq_pkg::ST_DELETED;
                    n_state      = S_IDLE;
                end
            end

            S_DNX: begin
                w_we    = 1'b1;
                w_waddr = r_link;
                w_wdata = {DELAY_BITS'(w_rd_dly + r_rem), w_rd_nxt};
                if (r_has_prv) begin
                    n_state = S_DWR_PRV;
                end else begin
                    n_head          = r_link;
                    n_pending[r_id] = 1'b0;
                    n_count         = CW'(r_count - 1'b1);
                    n_strobe        = 1'b1;
                    n_res.status    = dtq_pkg::ST_DELETED;
                    n_state         = S_IDLE;
                end
            end

            S_DWR_PRV: begin
                w_we            = 1'b1;
                w_waddr         = r_prev;
                w_wdata         = {r_prv_dly, r_link};
                n_pending[r_id] = 1'b0;
                n_count         = CW'(r_count - 1'b1);
                n_strobe        = 1'b1;
                n_res.status    = dtq_pkg::ST_DELETED;
                n_state         = S_IDLE;
            end

            S_TCHK: begin
                n_res.status    = dtq_pkg::ST_EXPIRED;
                n_res.no_expiry = 1'b0;
                if (w_tdly == '0) begin
                    // head expires: release the earlier one, hold this one
                    if (r_have_pend) begin
                        n_strobe           = 1'b1;
                        n_res.timer_id_res = 4'(r_pend);
                        n_res.last         = 1'b0;
                    end
                    n_pend            = r_head;
                    n_have_pend       = 1'b1;
                    n_nres            = w_nres1;
                    n_first           = 1'b0;
                    n_pending[r_head] = 1'b0;
                    n_count           = CW'(r_count - 1'b1);
                    n_head            = (r_count == CW'(1)) ? '0 : w_rd_nxt;
                    w_raddr           = w_rd_nxt;
                    if ((r_count == CW'(1)) || (w_nres1 == NW'(dtq_pkg::MAX_RESULTS))) begin
                        n_state = S_TFLUSH;
                    end
                end else begin
                    if (r_first) begin
                        w_we    = 1'b1;
                        w_waddr = r_head;
                        w_wdata = {w_tdly, w_rd_nxt};
                    end
                    n_strobe   = 1'b1;
                    n_res.last = 1'b1;
                    if (r_have_pend) begin
                        n_res.timer_id_res = 4'(r_pend);
                    end else begin
                        n_res.timer_id_res = '0;
                        n_res.no_expiry    = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end

            S_TFLUSH: begin
                n_strobe           = 1'b1;
                n_res.timer_id_res = 4'(r_pend);
                n_res.status       = dtq_pkg::ST_EXPIRED;
                n_res.no_expiry    = 1'b0;
                n_res.last         = 1'b1;
                n_state            = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pending   <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_strobe    <= 1'b0;
            r_have_pend <= 1'b0;
            r_first     <= 1'b0;
            r_has_prv   <= 1'b0;
            r_k         <= '0;
            r_nres      <= '0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_head      <= n_head;
            r_count     <= n_count;
            r_strobe    <= n_strobe;
            r_have_pend <= n_have_pend;
            r_first     <= n_first;
            r_has_prv   <= n_has_prv;
            r_k         <= n_k;
            r_nres      <= n_nres;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id      <= n_id;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_link    <= n_link;
        r_rem     <= n_rem;
        r_prv_dly <= n_prv_dly;
        r_pend    <= n_pend;
        r_res     <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    `ASSERT_IMPLY(a_count_bits, i_clk, i_rst_n, 1'b1, $countones(r_pending) == int'(r_count))
    `ASSERT_IMPLY(a_empty_head, i_clk, i_rst_n, r_count == '0, r_head == '0)
    `ASSERT_IMPLY(a_count_max, i_clk, i_rst_n, 1'b1, int'(r_count) <= TIMER_SLOTS)
    `ASSERT_NEXT(a_add_ends, i_clk, i_rst_n, r_state == S_AWR_PRV, o_strobe && r_state == S_IDLE)

endmodule

// ----- verif/dtq_checker.sv -----
// Checker for the delta-list timer queue: watches accepted items and strobed
// results, predicts the results and compares them. Depends on dtq_pkg.
module dtq_checker
    import dtq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  logic    busy,
    input  t_item   i_item,
    input  logic    o_strobe,
    input  t_result o_result,
    output int      o_fail_count,
    output int      o_pending,
    output int      o_expired
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [23:0] slot_dly  [16];
    bit          slot_live [16];
    logic [3:0]  slot_succ [16];
    logic [3:0]  head_slot;
    int          live_count;
    t_result     awaited_results[$];

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        o_fail_count++;
    endtask

    function automatic logic [2:0] link_timer(input logic [3:0] id, input logic [23:0] rem);
        logic [3:0] cur, prev;
        bit has_prev;
        int k;
        cur = head_slot;
        prev = '0;
        has_prev = 0;
        if (slot_live[id]) return ST_BUSY;
        if (rem == 0) return ST_ZERO_DLY;
        for (k = 0; k < live_count; k++) begin
            if (rem < slot_dly[cur]) begin
                slot_dly[cur] -= rem;
                break;
            end
            rem -= slot_dly[cur];
            prev = cur;
            has_prev = 1;
            cur = slot_succ[cur];
        end
        slot_dly[id]  = rem;
        slot_succ[id] = (k < live_count) ? cur : 4'd0;
        if (has_prev) slot_succ[prev] = id;
        else head_slot = id;
        slot_live[id] = 1;
        live_count++;
        return ST_ADDED;
    endfunction

    function automatic logic [2:0] drop_timer(input logic [3:0] id);
        logic [3:0] cur, prev, nx;
        bit has_prev;
        int k;
        cur = head_slot;
        prev = '0;
        has_prev = 0;
        if (!slot_live[id]) return ST_IDLE;
        for (k = 0; k < live_count && cur != id; k++) begin
            prev = cur;
            has_prev = 1;
            cur = slot_succ[cur];
        end
        if (k + 1 < live_count) begin
            nx = slot_succ[id];
            slot_dly[nx] = slot_dly[nx] + slot_dly[id];
            if (has_prev) slot_succ[prev] = nx;
            else head_slot = nx;
        end
        slot_live[id] = 0;
        live_count--;
        if (live_count == 0) head_slot = '0;
        return ST_DELETED;
    endfunction

    // Work out every result of one accepted item and queue it.
    task automatic predict_timer_results(input t_item it);
        t_result r;
        int n;
        n = 0;
        r = '0;
        case (it.action)
            ACT_ADD: begin
                r.timer_id_res = it.timer_id;
                r.status = link_timer(it.timer_id, it.delay);
                r.last = 1'b1;
                awaited_results.push_back(r);
            end
            ACT_DEL: begin
                r.timer_id_res = it.timer_id;
                r.status = drop_timer(it.timer_id);
                r.last = 1'b1;
                awaited_results.push_back(r);
            end
            ACT_TICK: begin
                if (live_count > 0) begin
                    if (slot_dly[head_slot] != 0) slot_dly[head_slot]--;
                    while (live_count > 0 && n < MAX_RESULTS && slot_dly[head_slot] == 0) begin
                        r = '0;
                        r.timer_id_res = head_slot;
                        r.status = ST_EXPIRED;
                        awaited_results.push_back(r);
                        void'(drop_timer(head_slot));
                        n++;
                    end
                end
                if (n == 0) begin
                    r = '0;
                    r.status = ST_EXPIRED;
                    r.no_expiry = 1'b1;
                    r.last = 1'b1;
                    awaited_results.push_back(r);
                end else begin
                    awaited_results[$].last = 1'b1;
                    o_expired += n;
                end
            end
            default: ;
        endcase
    endtask

    initial begin
        o_fail_count = 0;
        o_expired = 0;
        live_count = 0;
        head_slot = '0;
        foreach (slot_live[i]) slot_live[i] = 0;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (awaited_results.size() == 0) begin
                report($sformatf("unexpected result %p", o_result));
            end else begin
                want = awaited_results.pop_front();
                if (o_result.timer_id_res !== want.timer_id_res)
                    report($sformatf("timer_id_res %0d, want %0d",
                                     o_result.timer_id_res, want.timer_id_res));
                if (o_result.status !== want.status)
                    report($sformatf("status %0d, want %0d", o_result.status, want.status));
                if (o_result.no_expiry !== want.no_expiry)
                    report($sformatf("no_expiry %b, want %b",
                                     o_result.no_expiry, want.no_expiry));
                if (o_result.last !== want.last)
                    report($sformatf("last %b, want %b", o_result.last, want.last));
            end
        end
        if (i_rst_n && start && !busy) predict_timer_results(i_item);
        o_pending = awaited_results.size();
    end

endmodule

// ----- verif/testbench.sv -----
// Top of the timer queue testbench: clock, reset, item stimulus and verdict.
// Depends on dtq_pkg, delta_timer_queue and dtq_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dtq_pkg::*;

    // action code with no meaning to the block
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_item   i_item = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;
    int      fail_count, pending_count, expired_count;
    int      taken_count = 0;
    int      item_total = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    delta_timer_queue i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    dtq_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (i_item),
        .o_strobe     (o_strobe),
        .o_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_expired    (expired_count)
    );

    // Count handshakes at the rising edge; the driver looks at the count on
    // the following falling edge, so it never races the block's outputs.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) taken_count <= taken_count + 1;
    end

    // Offer one item from a falling edge and hold it until it is taken.
    // With gaps allowed, sometimes drop start for a random number of cycles first.
    task automatic send_item(input logic [1:0] act, input logic [3:0] id,
                             input logic [23:0] dly, input bit allow_gap);
        int seen;
        if (allow_gap && $urandom_range(99) < 27) begin
            start = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        seen = taken_count;
        start = 1'b1;
        i_item.action = act;
        i_item.timer_id = id;
        i_item.delay = dly;
        do @(negedge i_clk); while (taken_count == seen);
        item_total++;
    endtask

    // Pick a delay: mostly short so timers actually expire, some full width
    // so that every delay bit toggles.
    function automatic logic [23:0] pick_delay();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5) return '0;
        if (sel < 75) return 24'($urandom_range(1, 6));
        if (sel < 90) return 24'($urandom_range(7, 40));
        return 24'($urandom);
    endfunction

    initial begin
        int pick;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: single expiry, zero delay, add of a pending slot,
        // deletes of idle and pending slots, empty tick, unknown action.
        send_item(ACT_ADD, 4'd0, 24'd1, 0);
        send_item(ACT_TICK, 4'd0, '0, 0);
        send_item(ACT_TICK, 4'd9, '0, 0);
        send_item(ACT_ADD, 4'd3, 24'd0, 0);
        send_item(ACT_ADD, 4'd15, 24'hFFFFFF, 0);
        send_item(ACT_ADD, 4'd15, 24'd2, 0);
        send_item(ACT_DEL, 4'd7, '0, 0);
        send_item(ACT_DEL, 4'd15, '0, 0);
        send_item(ACT_UNUSED, 4'd5, 24'h5A5A5A, 0);
        // Fill every slot with equal deadlines: one tick expires all sixteen.
        for (int s = 0; s < 16; s++) send_item(ACT_ADD, 4'(s), 24'd1, 0);
        send_item(ACT_TICK, 4'd0, '0, 0);

        // Random: a gap-free stretch in the middle, and one full drain.
        for (int n = 0; n < 450; n++) begin
            if (n == 300) begin
                start = 1'b0;
                while (pending_count != 0) @(negedge i_clk);
            end
            pick = $urandom_range(99);
            if (pick < 38)
                send_item(ACT_ADD, 4'($urandom), pick_delay(), !(n >= 150 && n < 250));
            else if (pick < 55)
                send_item(ACT_DEL, 4'($urandom), 24'($urandom), !(n >= 150 && n < 250));
            else if (pick < 96)
                send_item(ACT_TICK, 4'($urandom), 24'($urandom), !(n >= 150 && n < 250));
            else
                send_item(ACT_UNUSED, 4'($urandom), 24'($urandom), !(n >= 150 && n < 250));
        end
        start = 1'b0;

        // Drain: wait for every expected result, then keep watching for stray ones.
        while (pending_count != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        $display("Run covered %0d items (adds, deletes, ticks, unknown actions) "
                 , item_total);
        $display("with %0d timer expiries checked.", expired_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Hold a hard ceiling on run time in case the block hangs.
    initial begin
        #2ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
